@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modular exponentiation assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modular exponentiation assertion failed");

`endif

@@ rtl/core/mexp_pkg.sv @@
// Package for the modular exponentiation core: widths, types, reduction helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	localparam int EXP_WIDTH = 63;   // exponent bits that take part, 2..63
	localparam int WORD_W    = 63;   // base, exponent and modulus fields
	localparam int RES_W     = 62;   // reduced residues

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RES_W-1:0]  res_t;

	localparam word_t MOD_RESET = 63'd1000000007;
	localparam word_t MOD_MAX   = word_t'(1) << RES_W;   // 2^62
	localparam word_t MOD_ONE   = word_t'(1);
	localparam word_t MOD_TWO   = word_t'(2);

	// request to the shift-and-add modular multiplier
	typedef struct packed {
		logic  start;
		res_t  a;      // multiplicand, below m
		word_t b;      // multiplier, scanned LSB first
		word_t m;      // effective modulus
	} mm_req_t;

	typedef struct packed {
		logic done;
		res_t prod;
	} mm_rsp_t;

	// s < 2m, m <= 2^62: one conditional subtract gives s mod m
	function automatic res_t mod_reduce(input word_t s, input word_t m);
		word_t diff;
		diff = s - m;
		return (s >= m) ? diff[RES_W-1:0] : s[RES_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/mexp_if.sv @@
// Valid/ready channel interfaces for the modular exponentiation core.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_cmd_if
	import mexp_pkg::*;
;
	logic  valid;
	logic  ready;
	logic  func;
	word_t base;
	word_t exponent;

	modport source (output valid, func, base, exponent, input ready);
	modport sink   (input valid, func, base, exponent, output ready);
endinterface

interface mexp_rsp_if
	import mexp_pkg::*;
;
	logic valid;
	logic ready;
	res_t result;
	logic error;

	modport source (output valid, result, error, input ready);
	modport sink   (input valid, result, error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mexp_mulmod.sv @@
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod
	import mexp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mm_req_t req,
	output mm_rsp_t      rsp
);

	logic  busy_q;
	res_t  acc_q;
	res_t  a_q;
	word_t b_q;
	word_t m_q;

	res_t  acc_nxt;
	res_t  dbl_nxt;
	logic  b_zero;

	assign b_zero  = (b_q == '0);
	assign acc_nxt = mod_reduce({1'b0, acc_q} + {1'b0, a_q}, m_q);
	assign dbl_nxt = mod_reduce({a_q, 1'b0}, m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_zero) begin
			busy_q <= 1'b0;
		end
	end

	// operand shift register and running sums
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
		end else if (busy_q && !b_zero) begin
			if (b_q[0]) begin
				acc_q <= acc_nxt;
			end
			a_q <= dbl_nxt;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = busy_q && b_zero;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/modular_exponentiation_core.sv @@
// Modular exponentiation core: sequencer, modulus register, output register.
// Depends on mexp_pkg, mexp_if, mexp_mulmod and assert_macros.svh.
//
//   channel  dir  fields                     transaction
//   cmd      in   func, base, exponent       cmd.valid && cmd.ready
//   rsp      out  result, error              rsp.valid && rsp.ready
//   cfg      in   cfg_wdata (modulus)        cfg_we, no back-pressure
//
// One transaction at a time. Base reduction runs first, then each exponent bit costs a
// step state plus a multiply when set and a squaring, all on the single shared
// shift-and-add multiplier.
// Reset clears the sequencer and output valid and loads modulus 1000000007.
// cmd.ready is high only in idle; a held result stalls only the final step.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation_core
	import mexp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	mexp_cmd_if.sink    cmd,
	mexp_rsp_if.source  rsp,
	input  wire logic   cfg_we,
	input  wire word_t  cfg_wdata
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,   // base mod m via 1 * base on the multiplier
		S_STEP = 6'b000100,   // look at the next exponent bit
		S_MUL  = 6'b001000,   // acc * x
		S_SQR  = 6'b010000,   // x * x
		S_FIN  = 6'b100000    // hand result to the output register
	} state_t;

	state_t state_q, state_d;

	// effective modulus: zero reads as one, saturated at 2^62
	word_t mod_q;
	word_t mod_eff;
	word_t mod_m2;
	logic  m_is_one;
	res_t  one_val;

	res_t                 acc_q;
	res_t                 x_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic                 err_q;

	logic out_valid_q;
	res_t result_q;
	logic error_q;

	logic    cmd_fire;
	logic    out_load;
	logic    err_case;
	mm_req_t mm_req;
	mm_rsp_t mm_rsp;
	logic    mm_wait;

	assign mod_eff  = (cfg_wdata == '0) ? MOD_ONE :
	                  (cfg_wdata > MOD_MAX) ? MOD_MAX : cfg_wdata;
	assign m_is_one = (mod_q == MOD_ONE);
	assign one_val  = m_is_one ? res_t'(0) : res_t'(1);
	assign mod_m2   = mod_q - MOD_TWO;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign err_case  = cmd.func && m_is_one;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign mm_wait   = (state_q == S_RED) || (state_q == S_MUL) || (state_q == S_SQR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			mod_q <= mod_eff;
		end
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	// sequencer; multiplier starts are issued on the transition into a wait state
	always_comb begin
		state_d      = state_q;
		mm_req.start = 1'b0;
		mm_req.a     = x_q;
		mm_req.b     = {1'b0, x_q};
		mm_req.m     = mod_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					if (err_case) begin
						state_d = S_FIN;
					end else begin
						mm_req.start = 1'b1;
						mm_req.a     = one_val;
						mm_req.b     = cmd.base;
						state_d      = S_RED;
					end
				end
			end
			S_RED: begin
				if (mm_rsp.done) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (e_q == '0) begin
					state_d = S_FIN;
				end else if (e_q[0]) begin
					mm_req.start = 1'b1;
					mm_req.a     = acc_q;
					state_d      = S_MUL;
				end else begin
					mm_req.start = 1'b1;
					state_d      = S_SQR;
				end
			end
			S_MUL: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;   // square x next, x is unchanged here
					state_d      = S_SQR;
				end
			end
			S_SQR: begin
				if (mm_rsp.done) begin
					state_d = S_STEP;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			acc_q <= one_val;
			err_q <= err_case;
			e_q   <= cmd.func ? mod_m2[EXP_WIDTH-1:0] : cmd.exponent[EXP_WIDTH-1:0];
		end
		if (mm_rsp.done) begin
			case (state_q)
				S_RED: begin
					x_q <= mm_rsp.prod;
				end
				S_MUL: begin
					acc_q <= mm_rsp.prod;
				end
				S_SQR: begin
					x_q <= mm_rsp.prod;
					e_q <= e_q >> 1;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= acc_q;
			error_q  <= err_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.result = result_q;
	assign rsp.error  = error_q;

	`MEXP_ASSERT_IMP(a_err_zero, rsp.valid && rsp.error, rsp.result == '0)
	`MEXP_ASSERT_IMP(a_done_wait, mm_rsp.done, mm_wait)
	`MEXP_ASSERT_NXT(a_cmd_busy, cmd_fire, state_q != S_IDLE)
	`MEXP_ASSERT_NXT(a_out_load, out_load, out_valid_q && (state_q == S_IDLE))

endmodule

`default_nettype wire
